FILE: sv/vbd_pkg.sv
// ----------------------------------------------------------------------------
// vbd_pkg
// Shared types, sizes and helpers for the 2x2x2 volume downsampler.
// ----------------------------------------------------------------------------
package vbd_pkg;

  // Volume limits and data widths
  localparam int MAX_X        = 256;
  localparam int MAX_Y        = 256;
  localparam int MAX_Z        = 256;
  localparam int SAMPLE_WIDTH = 32;
  localparam int SUM_W        = SAMPLE_WIDTH + 3;
  localparam int SIZE_W       = 9;

  // Sum plane geometry
  localparam int PLANE_W      = MAX_X / 2;
  localparam int PLANE_DEPTH  = (MAX_X / 2) * (MAX_Y / 2);
  localparam int ADDR_W       = $clog2(PLANE_DEPTH);

  // Position counter widths
  localparam int POS_X_W      = $clog2(MAX_X);
  localparam int POS_Y_W      = $clog2(MAX_Y);
  localparam int POS_Z_W      = $clog2(MAX_Z);

  // Width wide enough for a size register and every cap
  localparam int CAP_W0       = $clog2(MAX_X + 1);
  localparam int CAP_W1       = ($clog2(MAX_Y + 1) > CAP_W0) ? $clog2(MAX_Y + 1) : CAP_W0;
  localparam int CAP_W2       = ($clog2(MAX_Z + 1) > CAP_W1) ? $clog2(MAX_Z + 1) : CAP_W1;
  localparam int EFF_W        = (SIZE_W > CAP_W2) ? SIZE_W : CAP_W2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(128);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_t;

  typedef logic [EFF_W-1:0] eff_t;

  // Effective size: drop the low bit, floor at two, cap at the limit
  function automatic eff_t eff_size(logic [SIZE_W-1:0] r, eff_t cap);
    eff_t s;
    s = EFF_W'({r[SIZE_W-1:1], 1'b0});
    if (s < EFF_W'(2)) s = EFF_W'(2);
    if (s > cap) s = cap;
    return s;
  endfunction

endpackage

FILE: sv/vbd_ram.sv
// ----------------------------------------------------------------------------
// vbd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module vbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a same-address write returns the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/volume_box_downsample_2x.sv
// ----------------------------------------------------------------------------
// volume_box_downsample_2x
// Averages each 2x2x2 cube of a raster-order voxel stream into one sample,
// keeping partial sums for one plane of cubes in a RAM.
// ----------------------------------------------------------------------------
// Path: a cube's eighth voxel is registered in stage 1, and its result is then
//   written into the output queue, from which it is offered.
// Throughput: one voxel per cycle while the receiver keeps up; the input
//   stalls while two results are queued or about to be. The sum plane RAM is
//   read when a voxel is taken and written back the next cycle, with a bypass.
// Reset: positions return to zero and sizes to 128; the sum plane is not cleared.
module volume_box_downsample_2x
  import vbd_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [SIZE_W-1:0]              cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_average,
  output logic                           out_last_of_volume
);

  // Configuration and position registers
  logic [SIZE_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [POS_X_W-1:0] pos_x_r, pos_x_nxt;
  logic [POS_Y_W-1:0] pos_y_r, pos_y_nxt;
  logic [POS_Z_W-1:0] pos_z_r, pos_z_nxt;

  eff_t ex, ey, ez;
  logic [POS_X_W-1:0] cx;
  logic [POS_Y_W-1:0] cy;
  logic [POS_Z_W-1:0] cz;
  logic               in_acc;
  logic [ADDR_W-1:0]  rd_addr;
  logic               first_c, emit_c, last_c;

  // Stage 1: read-modify-write of the sum entry
  logic                           s1_v_r, s1_first_r, s1_emit_r, s1_last_r;
  logic [ADDR_W-1:0]              s1_addr_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic signed [SUM_W-1:0]        ram_rdata, operand, sum_wdata;
  logic                           fwd_hit_r;
  logic signed [SUM_W-1:0]        fwd_data_r;

  // Two-entry output queue
  logic signed [SAMPLE_WIDTH-1:0] q_avg_r  [2];
  logic                           q_last_r [2];
  logic                           q_wptr_r, q_rptr_r;
  logic [1:0]                     q_cnt_r, q_cnt_nxt;
  logic                           q_push, q_pop;

  // Effective sizes and clamped position of the current voxel
  always_comb begin
    ex = eff_size(size_x_r, EFF_W'(MAX_X));
    ey = eff_size(size_y_r, EFF_W'(MAX_Y));
    ez = eff_size(size_z_r, EFF_W'(MAX_Z));
    cx = (EFF_W'(pos_x_r) < ex) ? pos_x_r : '0;
    cy = (EFF_W'(pos_y_r) < ey) ? pos_y_r : '0;
    cz = (EFF_W'(pos_z_r) < ez) ? pos_z_r : '0;
  end

  // Classify the voxel and form its sum plane address
  always_comb begin
    rd_addr = ADDR_W'(ADDR_W'(cy >> 1) * ADDR_W'(PLANE_W) + ADDR_W'(cx >> 1));
    first_c = ~(cx[0] | cy[0] | cz[0]);
    emit_c  = cx[0] & cy[0] & cz[0];
    last_c  = (EFF_W'(cx) == ex - EFF_W'(1)) && (EFF_W'(cy) == ey - EFF_W'(1)) &&
              (EFF_W'(cz) == ez - EFF_W'(1));
  end

  // Advance the raster position
  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (in_acc) begin
      pos_x_nxt = cx;
      pos_y_nxt = cy;
      pos_z_nxt = cz;
      if (EFF_W'(cx) + EFF_W'(1) >= ex) begin
        pos_x_nxt = '0;
        if (EFF_W'(cy) + EFF_W'(1) >= ey) begin
          pos_y_nxt = '0;
          if (EFF_W'(cz) + EFF_W'(1) >= ez) begin
            pos_z_nxt = '0;
          end else begin
            pos_z_nxt = cz + POS_Z_W'(1);
          end
        end else begin
          pos_y_nxt = cy + POS_Y_W'(1);
        end
      end else begin
        pos_x_nxt = cx + POS_X_W'(1);
      end
    end
  end

  // Size registers and positions; any size write restarts at a cube corner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIZE_X: begin
          size_x_r <= cfg_wdata;
          pos_x_r  <= '0;
          pos_y_r  <= '0;
          pos_z_r  <= '0;
        end
        CFG_SIZE_Y: begin
          size_y_r <= cfg_wdata;
          pos_x_r  <= '0;
          pos_y_r  <= '0;
          pos_z_r  <= '0;
        end
        CFG_SIZE_Z: begin
          size_z_r <= cfg_wdata;
          pos_x_r  <= '0;
          pos_y_r  <= '0;
          pos_z_r  <= '0;
        end
        default: begin
          pos_x_r <= pos_x_nxt;
          pos_y_r <= pos_y_nxt;
          pos_z_r <= pos_z_nxt;
        end
      endcase
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

  // Hold input while the queue could not take one more result
  assign in_ready = (q_cnt_r + {1'b0, s1_v_r & s1_emit_r}) < 2'd2;
  assign in_acc   = in_valid & in_ready;

  // Sum plane
  vbd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (PLANE_DEPTH)
  ) u_plane (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_addr_r),
    .wdata (sum_wdata),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Take the bypassed word when the previous item wrote the entry just read
  assign operand   = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign sum_wdata = s1_first_r ? SUM_W'(s1_sample_r) : operand + SUM_W'(s1_sample_r);

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_v_r    <= in_acc;
      fwd_hit_r <= in_acc & s1_v_r & (s1_addr_r == rd_addr);
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    fwd_data_r <= sum_wdata;
    if (in_acc) begin
      s1_addr_r   <= rd_addr;
      s1_first_r  <= first_c;
      s1_emit_r   <= emit_c;
      s1_last_r   <= last_c;
      s1_sample_r <= in_sample;
    end
  end

  // Output queue
  assign q_push    = s1_v_r & s1_emit_r;
  assign q_pop     = out_valid & out_ready;
  assign q_cnt_nxt = q_cnt_r + {1'b0, q_push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r  <= '0;
      q_wptr_r <= 1'b0;
      q_rptr_r <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (q_push) q_wptr_r <= ~q_wptr_r;
      if (q_pop)  q_rptr_r <= ~q_rptr_r;
    end
  end

  // Floor of the mean is the arithmetic shift by three
  always_ff @(posedge clk) begin
    if (q_push) begin
      q_avg_r[q_wptr_r]  <= sum_wdata[SUM_W-1:3];
      q_last_r[q_wptr_r] <= s1_last_r;
    end
  end

  assign out_valid          = (q_cnt_r != 2'd0);
  assign out_average        = q_avg_r[q_rptr_r];
  assign out_last_of_volume = q_last_r[q_rptr_r];

  // Queue never holds more than two results
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 2'd2)
    else $error("output queue overflow");

  // A result leaving stage 1 always finds room
  a_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_emit_r) |-> (q_cnt_r < 2'd2))
    else $error("result pushed into full queue");

  // A bypass only follows a write-back and a read in the same cycle
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> ($past(s1_v_r) && s1_v_r))
    else $error("bypass without matching write-back");

endmodule
